@@ hw/rtl/lbr_pkg.sv @@
// Shared types, widths and codes for the letterbox bilinear resizer.
package lbr_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_PLANES_DEF = 3;

  localparam int DIM_W   = 9;   // register and scaled-size width
  localparam int NUM_W   = 26;  // dividend width of the shared divider
  localparam int FRAC_W  = 16;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int XACC_W  = 25;
  localparam int PROD_W  = XACC_W + WGT_W;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam logic [WGT_W-1:0] FRAC_ONE = WGT_W'(1) << FRAC_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_BOX_W  = 3'd2;
  localparam logic [2:0] REG_BOX_H  = 3'd3;
  localparam logic [2:0] REG_PLANES = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_BOUND, S_PROD1, S_PROD2, S_SCALE, S_SCALE_W, S_PLACE, S_TEST,
    S_YSETUP, S_YDIV1, S_YDIV1_W, S_YDIV2, S_YDIV2_W,
    S_XSETUP, S_XDIV1, S_XDIV1_W, S_XDIV2, S_XDIV2_W,
    S_RD, S_MUL, S_ACC, S_YMUL, S_YACC, S_DONE
  } lbr_state_t;

  // zero reads as one, above hi saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    int x;
    x = (v == '0) ? 1 : int'(v);
    if (x > hi) x = hi;
    return x[DIM_W-1:0];
  endfunction

  function automatic logic [1:0] clamp_planes(input logic [1:0] v, input int hi);
    int x;
    x = (v == 2'd0) ? 1 : int'(v);
    if (x > hi) x = hi;
    return x[1:0];
  endfunction

endpackage

@@ hw/rtl/lbr_div.sv @@
// Bit-serial restoring divider shared by the scaling, index and fraction steps.
module lbr_div
  import lbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DIM_W-1:0]  den,
  output logic              done,
  output logic [NUM_W-1:0]  quo,
  output logic [DIM_W-1:0]  rem
);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DIM_W-1:0] den_r;
  logic [DIM_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (running) begin
      rem <= fits ? DIM_W'(trial - {1'b0, den_r}) : trial[DIM_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/lbr_store.sv @@
// Planar frame store, one write port and one registered read port.
module lbr_store #(
  parameter int DEPTH  = 196608,
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/letterbox_bilinear_resizer.sv @@
// Top level: sequencer, shared multiplier and configuration of the resizer.
//
// Input channel: in_valid/in_stall carry op, column, line, plane, sample.
// A load (op 0) leaves the input free, is written to the frame store when its
// column, line and plane lie within the maxima, and gives no result. A fetch
// (op 1) gives exactly one result on out_valid/out_stall: pixel_value and
// inside_image. A fetch runs through one shared multiplier and one bit-serial
// divider (26 steps per division). Outside the box a fetch skips the scaling;
// outside the scaled image or on an unused plane it ends after the scaling and
// placement; inside it takes up to five divisions and four store reads, each
// read followed by a multiply and an add.
// in_stall is high from the cycle after a fetch is taken until its result
// moves to the output register; a result waiting there while out_stall is
// high does not block the next item, but a second fetch result holds the
// sequencer until the register frees.
// Configuration (cfg_en, cfg_index, cfg_data) writes one register per cycle
// and is meant for idle periods. Reset (rst, synchronous) returns registers
// to 256 x 256 source and box with three planes and empties the output; the
// frame store is not cleared and reads undefined until written.
module letterbox_bilinear_resizer
  import lbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_PLANES = MAX_PLANES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic [2:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic [7:0]       column,
  input  logic [7:0]       line,
  input  logic [1:0]       plane,
  input  logic [7:0]       sample,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       pixel_value,
  output logic             inside_image
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH  = MAX_PLANES * (2 ** (XW + YW));
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lbr_state_t state, state_next;

  logic [DIM_W-1:0] src_w, src_h, box_w, box_h;
  logic [1:0]       planes;

  logic [7:0]  f_col, f_line;
  logic [1:0]  f_plane;
  logic [17:0] t1;
  logic        landscape;
  logic [DIM_W-1:0] nw, nh, ox, oy, c, r, ix, iy;
  logic [FRAC_W-1:0] fx, fy;
  logic        k, row;
  logic [XACC_W-1:0] xacc;
  logic [39:0] vacc;
  logic [7:0]  res_pix;
  logic        res_in;

  logic [XACC_W-1:0] mul_a;
  logic [WGT_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DIM_W-1:0]  div_den, div_rem;

  logic              st_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [7:0]        st_rdata;

  logic in_take, land_now, out_free, outside, edge_x;
  logic [DIM_W:0]    col_x, lin_x;
  logic [31:0]       waddr_w, raddr_w;
  logic [XACC_W-1:0] xacc_sum;
  logic [39:0]       vacc_sum;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign land_now = t1 < prod[17:0];
  assign out_free = !out_valid || !out_stall;
  assign col_x    = {2'b00, f_col};
  assign lin_x    = {2'b00, f_line};
  assign outside  = (col_x < {1'b0, ox}) || (col_x >= {1'b0, ox} + {1'b0, nw}) ||
                    (lin_x < {1'b0, oy}) || (lin_x >= {1'b0, oy} + {1'b0, nh});
  assign edge_x   = (c == nw - 1'b1) || (src_w == DIM_W'(1));
  assign xacc_sum = xacc + prod[XACC_W-1:0];
  assign vacc_sum = vacc + prod[39:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w  <= clamp_dim(DIM_W'(256), MAX_WIDTH);
      src_h  <= clamp_dim(DIM_W'(256), MAX_HEIGHT);
      box_w  <= DIM_W'(256);
      box_h  <= DIM_W'(256);
      planes <= clamp_planes(2'd3, MAX_PLANES);
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_SRC_W:  src_w  <= clamp_dim(cfg_data, MAX_WIDTH);
        REG_SRC_H:  src_h  <= clamp_dim(cfg_data, MAX_HEIGHT);
        REG_BOX_W:  box_w  <= clamp_dim(cfg_data, 511);
        REG_BOX_H:  box_h  <= clamp_dim(cfg_data, 511);
        REG_PLANES: planes <= clamp_planes(cfg_data[1:0], MAX_PLANES);
        default: ;
      endcase
    end
  end

  // load path and store read address
  assign st_we    = in_take && (op == OP_LOAD) && (32'(column) < MAX_WIDTH) &&
                    (32'(line) < MAX_HEIGHT) && (32'(plane) < MAX_PLANES);
  assign waddr_w  = (32'(plane) << (XW + YW)) | (32'(line) << XW) | 32'(column);
  assign st_waddr = waddr_w[ADDR_W-1:0];
  assign raddr_w  = (32'(f_plane) << (XW + YW)) | (32'(iy + DIM_W'(row)) << XW) |
                    32'(ix + DIM_W'(k));
  assign st_raddr = raddr_w[ADDR_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_take && op == OP_FETCH) state_next = S_BOUND;
      S_BOUND:   state_next = ({1'b0, f_col} >= box_w || {1'b0, f_line} >= box_h) ?
                              S_DONE : S_PROD1;
      S_PROD1:   state_next = S_PROD2;
      S_PROD2:   state_next = S_SCALE;
      S_SCALE:   state_next = S_SCALE_W;
      S_SCALE_W: if (div_done) state_next = S_PLACE;
      S_PLACE:   state_next = S_TEST;
      S_TEST:    state_next = (outside || f_plane >= planes) ? S_DONE : S_YSETUP;
      S_YSETUP:  state_next = (nh == DIM_W'(1)) ? S_XSETUP : S_YDIV1;
      S_YDIV1:   state_next = S_YDIV1_W;
      S_YDIV1_W: if (div_done) state_next = S_YDIV2;
      S_YDIV2:   state_next = S_YDIV2_W;
      S_YDIV2_W: if (div_done) state_next = S_XSETUP;
      S_XSETUP:  state_next = edge_x ? S_RD : S_XDIV1;
      S_XDIV1:   state_next = S_XDIV1_W;
      S_XDIV1_W: if (div_done) state_next = S_XDIV2;
      S_XDIV2:   state_next = S_XDIV2_W;
      S_XDIV2_W: if (div_done) state_next = S_RD;
      S_RD:      state_next = S_MUL;
      S_MUL:     state_next = S_ACC;
      S_ACC:     state_next = (!k && fx != '0) ? S_RD : S_YMUL;
      S_YMUL:    state_next = S_YACC;
      S_YACC:    state_next = (!row && fy != '0) ? S_RD : S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // shared multiplier and divider operands
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DIM_W'(1);
    unique case (state)
      S_BOUND: begin
        mul_a = XACC_W'(box_w);
        mul_b = WGT_W'(src_h);
      end
      S_PROD1: begin
        mul_a = XACC_W'(box_h);
        mul_b = WGT_W'(src_w);
      end
      S_PROD2: begin
        mul_a = land_now ? XACC_W'(src_h) : XACC_W'(src_w);
        mul_b = land_now ? WGT_W'(box_w) : WGT_W'(box_h);
      end
      S_SCALE: begin
        div_start = 1'b1;
        div_num   = prod[NUM_W-1:0];
        div_den   = landscape ? src_w : src_h;
      end
      S_YSETUP: begin
        mul_a = XACC_W'(r);
        mul_b = WGT_W'(src_h - 1'b1);
      end
      S_YDIV1: begin
        div_start = 1'b1;
        div_num   = prod[NUM_W-1:0];
        div_den   = nh - 1'b1;
      end
      S_YDIV2: begin
        div_start = 1'b1;
        div_num   = NUM_W'({div_rem, {FRAC_W{1'b0}}});
        div_den   = nh - 1'b1;
      end
      S_XSETUP: begin
        mul_a = XACC_W'(c);
        mul_b = WGT_W'(src_w - 1'b1);
      end
      S_XDIV1: begin
        div_start = 1'b1;
        div_num   = prod[NUM_W-1:0];
        div_den   = nw - 1'b1;
      end
      S_XDIV2: begin
        div_start = 1'b1;
        div_num   = NUM_W'({div_rem, {FRAC_W{1'b0}}});
        div_den   = nw - 1'b1;
      end
      S_MUL: begin
        mul_a = XACC_W'(st_rdata);
        mul_b = k ? WGT_W'(fx) : FRAC_ONE - WGT_W'(fx);
      end
      S_YMUL: begin
        mul_a = xacc;
        mul_b = row ? WGT_W'(fy) : FRAC_ONE - WGT_W'(fy);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_take) begin
        f_col   <= column;
        f_line  <= line;
        f_plane <= plane;
      end
      S_BOUND: begin
        res_pix <= '0;
        res_in  <= 1'b0;
      end
      S_PROD1: t1 <= prod[17:0];
      S_PROD2: landscape <= land_now;
      S_SCALE_W: if (div_done) begin
        nw <= landscape ? box_w : div_quo[DIM_W-1:0];
        nh <= landscape ? div_quo[DIM_W-1:0] : box_h;
      end
      S_PLACE: begin
        ox <= (box_w - nw) >> 1;
        oy <= (box_h - nh) >> 1;
      end
      S_TEST: begin
        res_in <= !outside;
        c      <= DIM_W'(f_col) - ox;
        r      <= DIM_W'(f_line) - oy;
      end
      S_YSETUP: if (nh == DIM_W'(1)) begin
        iy <= '0;
        fy <= '0;
      end
      S_YDIV1_W: if (div_done) iy <= div_quo[DIM_W-1:0];
      S_YDIV2_W: if (div_done) fy <= div_quo[FRAC_W-1:0];
      S_XSETUP: begin
        k    <= 1'b0;
        row  <= 1'b0;
        xacc <= '0;
        vacc <= '0;
        if (edge_x) begin
          ix <= src_w - 1'b1;
          fx <= '0;
        end
      end
      S_XDIV1_W: if (div_done) ix <= div_quo[DIM_W-1:0];
      S_XDIV2_W: if (div_done) fx <= div_quo[FRAC_W-1:0];
      S_ACC: begin
        xacc <= xacc_sum;
        k    <= 1'b1;
      end
      S_YACC: begin
        vacc    <= vacc_sum;
        row     <= 1'b1;
        k       <= 1'b0;
        xacc    <= '0;
        res_pix <= vacc_sum[39:32];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      pixel_value  <= res_pix;
      inside_image <= res_in;
    end
  end

  lbr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  lbr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (sample),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

@@ hw/rtl/lbr_chk.sv @@
// Port-level checks for the resizer, bound to the top level.
module lbr_chk
  import lbr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_value,
  input logic       inside_image
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_image |-> pixel_value == 8'd0)
    else $error("nonzero pixel outside the image");

  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_FETCH |=> in_stall)
    else $error("fetch did not occupy the sequencer");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_LOAD |=> !in_stall)
    else $error("load held the input");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind letterbox_bilinear_resizer lbr_chk u_lbr_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .op           (op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_value  (pixel_value),
  .inside_image (inside_image)
);
